/* hdl/dqoc_pkg.sv */
package dqoc_pkg;

	localparam int DEPTH = 512;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		REQ_PUSH_FRONT = 3'd0,
		REQ_PUSH_BACK  = 3'd1,
		REQ_POP_FRONT  = 3'd2,
		REQ_CHECK_ASC  = 3'd3,
		REQ_CHECK_DESC = 3'd4
	} req_code_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_CHECK
	} state_t;

	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [31:0] value_in;
		logic [9:0]         check_count;
	} req_t;

	typedef struct packed {
		logic signed [31:0] value_out;
		logic               order_ok;
		logic [1:0]         status;
		logic [9:0]         fill_level;
	} rsp_t;

	// Ring slot of the entry that sits off places behind the head.
	function automatic logic [IDX_W-1:0] slot_of(logic [IDX_W-1:0] head,
			logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
		if (sum >= (CNT_W+1)'(DEPTH)) begin
			sum = sum - (CNT_W+1)'(DEPTH);
		end
		return IDX_W'(sum);
	endfunction

endpackage

/* hdl/deque_with_order_check.sv */
// Bounded double-ended queue of signed 32-bit values held in a ring buffer of
// DEPTH entries (one single-port-write, one-read synchronous RAM) addressed by
// a head index and an entry count. A push is answered from ST_IDLE; a pop
// goes through ST_POP, since it waits on the registered RAM read. An order
// check over the first m = min(check_count, fill) entries streams them
// through the RAM read port one per cycle in ST_CHECK when m is two or
// more, and is answered from ST_IDLE otherwise. One request is worked on at
// a time; the result sits in an output register, and the next request is
// taken as soon as that register is free or being read. A push into a full
// queue is dropped with status 2, and a pop from an empty queue returns 0
// with status 1. No clearing pass is needed after reset.
module deque_with_order_check (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  dqoc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output dqoc_pkg::rsp_t rsp
);
	import dqoc_pkg::*;

	logic [31:0] mem [DEPTH];
	logic [31:0] mem_rdata_q;

	state_t state_q, state_d;
	logic [IDX_W-1:0] head_q, head_d;
	logic [CNT_W-1:0] count_q, count_d;

	logic [CNT_W-1:0] lim_q, lim_d;
	logic [CNT_W-1:0] iss_q, iss_d;
	logic [CNT_W-1:0] rcv_q, rcv_d;
	logic             ok_q, ok_d;
	logic             desc_q, desc_d;
	logic signed [31:0] prev_q;
	logic             rd_vld_s1;

	logic             mem_we, mem_re;
	logic [IDX_W-1:0] mem_waddr, mem_raddr;

	logic             rsp_valid_q;
	rsp_t             rsp_q, rsp_d;
	logic             load_rsp;

	logic             accept;
	logic [CNT_W-1:0] check_len;
	logic signed [31:0] cur;
	logic             pair_ok;

	assign accept = req_valid && req_ready;
	assign cur = $signed(mem_rdata_q);
	assign pair_ok = desc_q ? !(prev_q < cur) : !(prev_q > cur);

	always_comb begin
		if (32'(req.check_count) < 32'(count_q)) begin
			check_len = CNT_W'(req.check_count);
		end else begin
			check_len = count_q;
		end
	end

	always_comb begin
		state_d = state_q;
		head_d = head_q;
		count_d = count_q;
		lim_d = lim_q;
		iss_d = iss_q;
		rcv_d = rcv_q;
		ok_d = ok_q;
		desc_d = desc_q;
		mem_we = 1'b0;
		mem_waddr = head_q;
		mem_re = 1'b0;
		mem_raddr = head_q;
		load_rsp = 1'b0;
		rsp_d = '0;
		req_ready = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				req_ready = !rsp_valid_q || rsp_ready;
				if (accept) begin
					case (req.req_type) inside
						REQ_PUSH_FRONT: begin
							load_rsp = 1'b1;
							if (count_q >= CNT_W'(DEPTH)) begin
								rsp_d.status = STAT_FULL;
							end else begin
								head_d = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - 1'b1;
								mem_we = 1'b1;
								mem_waddr = head_d;
								count_d = count_q + 1'b1;
							end
							rsp_d.fill_level = 10'(count_d);
						end
						REQ_PUSH_BACK: begin
							load_rsp = 1'b1;
							if (count_q >= CNT_W'(DEPTH)) begin
								rsp_d.status = STAT_FULL;
							end else begin
								mem_we = 1'b1;
								mem_waddr = slot_of(head_q, count_q);
								count_d = count_q + 1'b1;
							end
							rsp_d.fill_level = 10'(count_d);
						end
						REQ_POP_FRONT: begin
							if (count_q == '0) begin
								load_rsp = 1'b1;
								rsp_d.status = STAT_EMPTY;
								rsp_d.fill_level = 10'(count_q);
							end else begin
								mem_re = 1'b1;
								mem_raddr = head_q;
								head_d = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
								count_d = count_q - 1'b1;
								state_d = ST_POP;
							end
						end
						REQ_CHECK_ASC, REQ_CHECK_DESC: begin
							desc_d = (req.req_type == REQ_CHECK_DESC);
							rsp_d.fill_level = 10'(count_q);
							if (count_q == '0) begin
								load_rsp = 1'b1;
							end else if (check_len <= CNT_W'(1)) begin
								load_rsp = 1'b1;
								rsp_d.order_ok = 1'b1;
							end else begin
								lim_d = check_len;
								iss_d = '0;
								rcv_d = '0;
								ok_d = 1'b1;
								state_d = ST_CHECK;
							end
						end
						default: begin
							load_rsp = 1'b1;
							rsp_d.fill_level = 10'(count_q);
						end
					endcase
				end
			end
			ST_POP: begin
				load_rsp = 1'b1;
				rsp_d.value_out = cur;
				rsp_d.fill_level = 10'(count_q);
				state_d = ST_IDLE;
			end
			ST_CHECK: begin
				// Reads are issued back to back; data returns in the cycle after each read.
				if (iss_q < lim_q) begin
					mem_re = 1'b1;
					mem_raddr = slot_of(head_q, iss_q);
					iss_d = iss_q + 1'b1;
				end
				if (rd_vld_s1) begin
					rcv_d = rcv_q + 1'b1;
					if (rcv_q != '0) begin
						ok_d = ok_q && pair_ok;
					end
					if (rcv_q == lim_q - 1'b1) begin
						load_rsp = 1'b1;
						rsp_d.order_ok = ok_d;
						rsp_d.fill_level = 10'(count_q);
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= req.value_in;
		end
		if (mem_re) begin
			mem_rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK && rd_vld_s1) begin
			prev_q <= cur;
		end
		if (load_rsp) begin
			rsp_q <= rsp_d;
		end
		lim_q <= lim_d;
		iss_q <= iss_d;
		rcv_q <= rcv_d;
		ok_q <= ok_d;
		desc_q <= desc_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q <= '0;
			count_q <= '0;
			rd_vld_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q <= head_d;
			count_q <= count_d;
			rd_vld_s1 <= mem_re;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule
